/* src/iaf_pkg.sv */
// Package for the integer-to-ASCII formatter: format codes, queue entry and state types,
// character constants and the hex digit function. No dependencies.
`default_nettype none

package iaf_pkg;

    localparam int VALUE_W    = 64;
    localparam int DEC_DIGITS = 20;
    localparam int BCD_W      = DEC_DIGITS * 4;

    typedef enum logic [1:0] {
        FMT_HEX16 = 2'd0,
        FMT_HEX64 = 2'd1,
        FMT_DEC   = 2'd2,
        FMT_NONE  = 2'd3
    } fmt_t;

    typedef struct packed {
        fmt_t                 fmt;
        logic [VALUE_W-1:0]   value;
    } job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEX,
        ST_CONV,
        ST_SKIP,
        ST_DEC
    } state_t;

    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_ALPHA = 7'h41;
    localparam logic [6:0] CH_X     = 7'h78;
    localparam logic [6:0] CH_NL    = 7'h0A;

    localparam logic [4:0] IDX_PREFIX0 = 5'd0;
    localparam logic [4:0] IDX_PREFIX1 = 5'd1;
    localparam logic [4:0] HEX16_LAST  = 5'd6;
    localparam logic [4:0] HEX64_LAST  = 5'd18;
    localparam logic [5:0] CONV_LAST   = 6'(VALUE_W - 1);
    localparam logic [4:0] DIGITS_ALL  = 5'(DEC_DIGITS);

    function automatic logic [6:0] hex_char(input logic [3:0] nib);
        logic [6:0] ch;
        if (nib < 4'd10) begin
            ch = CH_ZERO + {3'b000, nib};
        end else begin
            ch = CH_ALPHA + {3'b000, nib - 4'd10};
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

/* src/iaf_front.sv */
// Front part of the formatter: accepts items, drops the unused format, masks the
// 16-bit hex value and holds the jobs in a two-entry queue. Uses iaf_pkg.
`default_nettype none

module iaf_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    input  wire logic [1:0]     cmd,
    input  wire logic [63:0]    value,
    output logic                job_valid,
    input  wire logic           job_ready,
    output iaf_pkg::job_t       job
);

    iaf_pkg::job_t  entry_reg [2];
    logic [1:0]     count_reg;
    logic [1:0]     count_next;
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    iaf_pkg::job_t  new_job;
    iaf_pkg::fmt_t  fmt;
    logic           push;
    logic           pop;

    assign fmt       = iaf_pkg::fmt_t'(cmd);
    assign req_ready = (count_reg != 2'd2);
    assign push      = req_valid && req_ready && (fmt != iaf_pkg::FMT_NONE);
    assign job_valid = (count_reg != 2'd0);
    assign pop       = job_valid && job_ready;
    assign job       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        new_job.fmt   = fmt;
        new_job.value = (fmt == iaf_pkg::FMT_HEX16) ? {48'd0, value[15:0]} : value;
    end

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= new_job;
        end
    end

endmodule

`default_nettype wire

/* src/iaf_back.sv */
// Back part of the formatter: emits hex text directly, or converts to decimal by
// shift-add-3 and emits the digits, through an output register. Uses iaf_pkg.
`default_nettype none

module iaf_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           job_valid,
    output logic                job_ready,
    input  wire iaf_pkg::job_t  job,
    output logic                char_valid,
    input  wire logic           char_ready,
    output logic [6:0]          char_out,
    output logic                last
);

    iaf_pkg::state_t            state_reg;
    iaf_pkg::state_t            state_next;
    iaf_pkg::fmt_t              fmt_reg;
    iaf_pkg::fmt_t              fmt_next;
    logic [iaf_pkg::VALUE_W-1:0] work_reg;
    logic [iaf_pkg::VALUE_W-1:0] work_next;
    logic [iaf_pkg::BCD_W-1:0]  bcd_reg;
    logic [iaf_pkg::BCD_W-1:0]  bcd_next;
    logic [iaf_pkg::BCD_W-1:0]  bcd_adj;
    logic [5:0]                 step_reg;
    logic [5:0]                 step_next;
    logic [4:0]                 idx_reg;
    logic [4:0]                 idx_next;
    logic [4:0]                 dig_reg;
    logic [4:0]                 dig_next;
    logic                       char_valid_reg;
    logic                       char_valid_next;
    logic [6:0]                 char_reg;
    logic                       last_reg;
    logic                       emit;
    logic [6:0]                 emit_char;
    logic                       emit_last;
    logic                       out_free;
    logic [4:0]                 hex_last;

    assign job_ready  = (state_reg == iaf_pkg::ST_IDLE);
    assign out_free   = !char_valid_reg || char_ready;
    assign char_valid = char_valid_reg;
    assign char_out   = char_reg;
    assign last       = last_reg;
    assign hex_last   = (fmt_reg == iaf_pkg::FMT_HEX16) ? iaf_pkg::HEX16_LAST
                                                        : iaf_pkg::HEX64_LAST;

    always_comb
    begin
        for (int d = 0; d < iaf_pkg::DEC_DIGITS; d++) begin
            if (bcd_reg[d*4 +: 4] >= 4'd5) begin
                bcd_adj[d*4 +: 4] = bcd_reg[d*4 +: 4] + 4'd3;
            end else begin
                bcd_adj[d*4 +: 4] = bcd_reg[d*4 +: 4];
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        fmt_next   = fmt_reg;
        work_next  = work_reg;
        bcd_next   = bcd_reg;
        step_next  = step_reg;
        idx_next   = idx_reg;
        dig_next   = dig_reg;
        emit       = 1'b0;
        emit_char  = iaf_pkg::CH_NL;
        emit_last  = 1'b0;
        case (state_reg)
            iaf_pkg::ST_IDLE:
            begin
                if (job_valid) begin
                    fmt_next  = job.fmt;
                    idx_next  = 5'd0;
                    step_next = 6'd0;
                    dig_next  = iaf_pkg::DIGITS_ALL;
                    bcd_next  = '0;
                    if (job.fmt == iaf_pkg::FMT_DEC) begin
                        work_next  = job.value;
                        state_next = iaf_pkg::ST_CONV;
                    end else begin
                        work_next  = (job.fmt == iaf_pkg::FMT_HEX16)
                                     ? {job.value[15:0], 48'd0} : job.value;
                        state_next = iaf_pkg::ST_HEX;
                    end
                end
            end
            iaf_pkg::ST_HEX:
            begin
                if (out_free) begin
                    emit     = 1'b1;
                    idx_next = idx_reg + 5'd1;
                    if (idx_reg == iaf_pkg::IDX_PREFIX0) begin
                        emit_char = iaf_pkg::CH_ZERO;
                    end else if (idx_reg == iaf_pkg::IDX_PREFIX1) begin
                        emit_char = iaf_pkg::CH_X;
                    end else if (idx_reg == hex_last) begin
                        emit_char  = iaf_pkg::CH_NL;
                        emit_last  = 1'b1;
                        state_next = iaf_pkg::ST_IDLE;
                    end else begin
                        emit_char = iaf_pkg::hex_char(work_reg[63:60]);
                        work_next = {work_reg[59:0], 4'd0};
                    end
                end
            end
            iaf_pkg::ST_CONV:
            begin
                bcd_next  = {bcd_adj[iaf_pkg::BCD_W-2:0], work_reg[63]};
                work_next = {work_reg[62:0], 1'b0};
                step_next = step_reg + 6'd1;
                if (step_reg == iaf_pkg::CONV_LAST) begin
                    state_next = iaf_pkg::ST_SKIP;
                end
            end
            iaf_pkg::ST_SKIP:
            begin
                if ((bcd_reg[79:76] == 4'd0) && (dig_reg > 5'd1)) begin
                    bcd_next = {bcd_reg[75:0], 4'd0};
                    dig_next = dig_reg - 5'd1;
                end else begin
                    state_next = iaf_pkg::ST_DEC;
                end
            end
            iaf_pkg::ST_DEC:
            begin
                if (out_free) begin
                    emit = 1'b1;
                    if (dig_reg == 5'd0) begin
                        emit_char  = iaf_pkg::CH_NL;
                        emit_last  = 1'b1;
                        state_next = iaf_pkg::ST_IDLE;
                    end else begin
                        emit_char = iaf_pkg::CH_ZERO + {3'b000, bcd_reg[79:76]};
                        bcd_next  = {bcd_reg[75:0], 4'd0};
                        dig_next  = dig_reg - 5'd1;
                    end
                end
            end
            default:
            begin
                state_next = iaf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (emit) begin
            char_valid_next = 1'b1;
        end else if (char_ready) begin
            char_valid_next = 1'b0;
        end else begin
            char_valid_next = char_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg      <= iaf_pkg::ST_IDLE;
            char_valid_reg <= 1'b0;
            step_reg       <= 6'd0;
            idx_reg        <= 5'd0;
            dig_reg        <= 5'd0;
            fmt_reg        <= iaf_pkg::FMT_HEX16;
        end else begin
            state_reg      <= state_next;
            char_valid_reg <= char_valid_next;
            step_reg       <= step_next;
            idx_reg        <= idx_next;
            dig_reg        <= dig_next;
            fmt_reg        <= fmt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        bcd_reg  <= bcd_next;
        if (emit) begin
            char_reg <= emit_char;
            last_reg <= emit_last;
        end
    end

    a_last_is_newline: assert property (@(posedge clk) disable iff (!rst_n)
        (char_valid_reg && last_reg) |-> (char_reg == iaf_pkg::CH_NL))
        else $error("last raised on a character other than newline");

    a_conv_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == iaf_pkg::ST_CONV && step_reg == iaf_pkg::CONV_LAST)
        |=> (state_reg == iaf_pkg::ST_SKIP))
        else $error("conversion did not end after the last bit");

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == iaf_pkg::ST_DEC || state_reg == iaf_pkg::ST_SKIP)
        |-> (dig_reg <= iaf_pkg::DIGITS_ALL && dig_reg != 5'd0
             || state_reg == iaf_pkg::ST_DEC))
        else $error("decimal digit count out of range");

    a_job_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (job_valid && job_ready) |=> (state_reg != iaf_pkg::ST_IDLE))
        else $error("accepted job did not start");

endmodule

`default_nettype wire

/* src/integer_to_ascii_formatter.sv */
// Integer-to-ASCII formatter, top level: front queue feeding the conversion back end.
// Depends on iaf_pkg, iaf_front and iaf_back.
// An item is loaded into the back end, which then emits 7 characters (16-bit hex), 19 characters
// (64-bit hex), or, for decimal, runs a shift-add-3 pass over all 64 bits, skips leading zero digits
// and emits digits plus one characters; one character per cycle without back-pressure.
// A two-entry queue takes items while the back end works; reset is asynchronous and empties it.
`default_nettype none

module integer_to_ascii_formatter (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    input  wire logic [1:0]     cmd,
    input  wire logic [63:0]    value,
    output logic                char_valid,
    input  wire logic           char_ready,
    output logic [6:0]          char_out,
    output logic                last
);

    iaf_pkg::job_t  job;
    logic           job_valid;
    logic           job_ready;

    iaf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .cmd       (cmd),
        .value     (value),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job)
    );

    iaf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (job_valid),
        .job_ready  (job_ready),
        .job        (job),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_out   (char_out),
        .last       (last)
    );

endmodule

`default_nettype wire
